### src/mdspi_pkg.sv
// ---------------------------------------------------------------------------
// mdspi_pkg
// Shared types, codes and reset contents for the multi-device SPI slave.
// ---------------------------------------------------------------------------
package mdspi_pkg;

	localparam int REGS_PER_DEVICE_DEF = 128;
	localparam int DEVICE_COUNT_DEF    = 5;

	// request kinds
	localparam logic [1:0] REQ_SEL_ON  = 2'd0;
	localparam logic [1:0] REQ_SEL_OFF = 2'd1;
	localparam logic [1:0] REQ_DATA    = 2'd2;
	localparam logic [1:0] REQ_LOAD    = 2'd3;

	// device codes
	localparam logic [2:0] DEV_NO_SEL  = 3'd0;
	localparam logic [2:0] DEV_IMU     = 3'd1;
	localparam logic [2:0] DEV_HG_L    = 3'd2;
	localparam logic [2:0] DEV_HG_R    = 3'd3;
	localparam logic [2:0] DEV_PR_L    = 3'd4;
	localparam logic [2:0] DEV_PR_R    = 3'd5;
	localparam logic [2:0] DEV_SEVERAL = 3'd7;

	localparam logic [7:0] BAD_SELECT_CODE = 8'hEE;
	localparam int         READ_FLAG_BIT   = 7;

	// register addresses
	localparam logic [6:0] ADDR_WHO_AM_I = 7'h0F;
	localparam logic [6:0] ADDR_CTRL1    = 7'h10;
	localparam logic [6:0] ADDR_CTRL2    = 7'h11;
	localparam logic [6:0] ADDR_CTRL_A   = 7'h20;
	localparam logic [6:0] ADDR_CTRL_B   = 7'h21;

	// reset contents
	localparam logic [7:0] ID_IMU     = 8'h6B;
	localparam logic [7:0] ID_HG      = 8'h32;
	localparam logic [7:0] ID_PR_L    = 8'hA1;
	localparam logic [7:0] ID_PR_R    = 8'hA2;
	localparam logic [7:0] DEF_IMU_C1 = 8'h94;
	localparam logic [7:0] DEF_IMU_C2 = 8'h9D;
	localparam logic [7:0] DEF_HG_C   = 8'h27;
	localparam logic [7:0] DEF_PR_C   = 8'h01;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] cs_lines;
		logic [7:0] rx_byte;
		logic [2:0] load_device;
		logic [6:0] load_address;
		logic [7:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       select_error;
	} out_item_t;

	// bank access request from the control logic
	typedef struct packed {
		logic       we;
		logic [2:0] wr_dev;
		logic [6:0] wr_addr;
		logic [7:0] wr_data;
		logic       re;
		logic [2:0] rd_dev;
		logic [6:0] rd_addr;
	} mem_req_t;

	// result of one item before the bank read data is merged in
	typedef struct packed {
		logic       use_rdata;
		logic [7:0] tx_byte;
		logic       select_error;
	} res_t;

	function automatic logic is_writable(input logic [2:0] dev, input logic [6:0] addr);
		logic w;
		w = 1'b0;
		case (dev) inside
			DEV_IMU:            w = (addr == ADDR_CTRL1) || (addr == ADDR_CTRL2);
			DEV_HG_L, DEV_HG_R: w = (addr == ADDR_CTRL_A);
			DEV_PR_L, DEV_PR_R: w = (addr == ADDR_CTRL_A) || (addr == ADDR_CTRL_B);
			default:            w = 1'b0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] reset_value(input logic [2:0] dev, input logic [6:0] addr);
		logic [7:0] v;
		v = 8'h00;
		case (dev) inside
			DEV_IMU: begin
				if (addr == ADDR_WHO_AM_I) v = ID_IMU;
				else if (addr == ADDR_CTRL1) v = DEF_IMU_C1;
				else if (addr == ADDR_CTRL2) v = DEF_IMU_C2;
			end
			DEV_HG_L, DEV_HG_R: begin
				if (addr == ADDR_WHO_AM_I) v = ID_HG;
				else if (addr == ADDR_CTRL_A) v = DEF_HG_C;
			end
			DEV_PR_L: begin
				if (addr == ADDR_WHO_AM_I) v = ID_PR_L;
				else if (addr == ADDR_CTRL_A) v = DEF_PR_C;
			end
			DEV_PR_R: begin
				if (addr == ADDR_WHO_AM_I) v = ID_PR_R;
				else if (addr == ADDR_CTRL_A) v = DEF_PR_C;
			end
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### src/multi_device_spi_register_slave.sv
// An accepted item is registered in item_s1; its result is registered in the output stage once the output is free.
// Throughput: one item per cycle unless the output stalls or the bank is filling; the bank
// has one write and one registered read port, and each item makes at most one access.
// Reset: control state clears asynchronously; the bank then writes its defaults into all
// DEVICE_COUNT * REGS_PER_DEVICE registers (640 by default) while in_ready is low.
// ---------------------------------------------------------------------------
// multi_device_spi_register_slave
// SPI register slave for several virtual devices with auto-increment access.
// ---------------------------------------------------------------------------
module multi_device_spi_register_slave
	import mdspi_pkg::*;
#(
	parameter int REGS_PER_DEVICE = REGS_PER_DEVICE_DEF,
	parameter int DEVICE_COUNT    = DEVICE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	in_item_t   item_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       use_rd_s2;
	logic [7:0] tx_s2;
	logic       err_s2;
	logic       fire;
	logic       busy;
	logic [7:0] rdata;
	mem_req_t   mreq;
	res_t       res;

	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !busy && (!valid_s1 || fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			use_rd_s2 <= res.use_rdata;
			tx_s2     <= res.tx_byte;
			err_s2    <= res.select_error;
		end
	end

	mdspi_ctrl #(
		.DEVICE_COUNT(DEVICE_COUNT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.mreq   (mreq),
		.res    (res)
	);

	mdspi_bank #(
		.REGS_PER_DEVICE(REGS_PER_DEVICE),
		.DEVICE_COUNT   (DEVICE_COUNT)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata),
		.busy   (busy)
	);

	assign out_valid             = valid_s2;
	assign out_data.tx_byte      = use_rd_s2 ? rdata : tx_s2;
	assign out_data.select_error = err_s2;

endmodule

### src/mdspi_bank.sv
// ---------------------------------------------------------------------------
// mdspi_bank
// Register bank of all devices: one write port, one registered read port,
// and a fill pass after reset that loads the identity and control defaults.
// ---------------------------------------------------------------------------
module mdspi_bank
	import mdspi_pkg::*;
#(
	parameter int REGS_PER_DEVICE = REGS_PER_DEVICE_DEF,
	parameter int DEVICE_COUNT    = DEVICE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rdata,
	output logic       busy
);

	localparam int DEPTH = DEVICE_COUNT * REGS_PER_DEVICE;
	localparam int AW    = $clog2(DEPTH);

	localparam logic ST_FILL = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          state_q;
	logic [2:0]    fill_dev_q;
	logic [6:0]    fill_addr_q;
	logic          fill_last;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	// address is taken modulo the per-device register count; exact only while it is below twice that count
	function automatic logic [AW-1:0] slot_of(input logic [2:0] dev, input logic [6:0] addr);
		logic [6:0] am;
		logic [2:0] di;
		am = ({1'b0, addr} >= 8'(REGS_PER_DEVICE)) ? addr - 7'(REGS_PER_DEVICE) : addr;
		di = dev - 3'd1;
		return AW'(int'(di) * REGS_PER_DEVICE) + AW'(am);
	endfunction

	assign fill_last = (fill_dev_q == 3'(DEVICE_COUNT)) &&
		(fill_addr_q == 7'(REGS_PER_DEVICE - 1));
	assign busy = (state_q == ST_FILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_dev_q  <= DEV_IMU;
			fill_addr_q <= 7'd0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (fill_last) begin
						state_q <= ST_RUN;
					end else if (fill_addr_q == 7'(REGS_PER_DEVICE - 1)) begin
						fill_addr_q <= 7'd0;
						fill_dev_q  <= fill_dev_q + 3'd1;
					end else begin
						fill_addr_q <= fill_addr_q + 7'd1;
					end
				end
				ST_RUN: state_q <= ST_RUN;
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_comb begin
		if (busy) begin
			we    = 1'b1;
			waddr = slot_of(fill_dev_q, fill_addr_q);
			wdata = reset_value(fill_dev_q, fill_addr_q);
		end else begin
			we    = req.we;
			waddr = slot_of(req.wr_dev, req.wr_addr);
			wdata = req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[slot_of(req.rd_dev, req.rd_addr)];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/mdspi_ctrl.sv
// ---------------------------------------------------------------------------
// mdspi_ctrl
// Transaction state and per-item decode: selects the device, tracks the
// command and auto-increment pointer, and issues bank reads and writes.
// ---------------------------------------------------------------------------
module mdspi_ctrl
	import mdspi_pkg::*;
#(
	parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output mem_req_t mreq,
	output res_t     res
);

	localparam int NSEL = (DEVICE_COUNT < 5) ? DEVICE_COUNT : 5;

	logic [2:0] dev_q, dev_d;
	logic       in_trans_q, in_trans_d;
	logic       await_cmd_q, await_cmd_d;
	logic [6:0] ptr_q, ptr_d;
	logic       read_mode_q, read_mode_d;
	logic [2:0] sampled;
	logic [6:0] ptr_inc;

	function automatic logic dev_valid(input logic [2:0] dev);
		return (dev != DEV_NO_SEL) && (dev <= 3'(DEVICE_COUNT));
	endfunction

	// active-low selects; lines past the device count are not looked at
	always_comb begin
		logic found;
		logic several;
		found   = 1'b0;
		several = 1'b0;
		sampled = DEV_NO_SEL;
		for (int i = 0; i < NSEL; i++) begin
			if (!item.cs_lines[i]) begin
				if (found) several = 1'b1;
				found   = 1'b1;
				sampled = 3'(i + 1);
			end
		end
		if (several) sampled = DEV_SEVERAL;
	end

	assign ptr_inc = ptr_q + 7'd1;

	always_comb begin
		dev_d       = dev_q;
		in_trans_d  = in_trans_q;
		await_cmd_d = await_cmd_q;
		ptr_d       = ptr_q;
		read_mode_d = read_mode_q;
		mreq        = '0;
		res         = '0;
		unique case (item.req_type)
			REQ_SEL_ON: begin
				if (!in_trans_q) begin
					in_trans_d  = 1'b1;
					dev_d       = DEV_NO_SEL;
					await_cmd_d = 1'b1;
					ptr_d       = 7'd0;
					read_mode_d = 1'b0;
				end
			end
			REQ_SEL_OFF: begin
				in_trans_d  = 1'b0;
				dev_d       = DEV_NO_SEL;
				await_cmd_d = 1'b1;
				ptr_d       = 7'd0;
				read_mode_d = 1'b0;
			end
			REQ_LOAD: begin
				if (dev_valid(item.load_device)) begin
					mreq.we      = 1'b1;
					mreq.wr_dev  = item.load_device;
					mreq.wr_addr = item.load_address;
					mreq.wr_data = item.load_value;
				end
			end
			REQ_DATA: begin
				if (in_trans_q) begin
					if (await_cmd_q) begin
						await_cmd_d = 1'b0;
						dev_d       = sampled;
						read_mode_d = item.rx_byte[READ_FLAG_BIT];
						ptr_d       = item.rx_byte[6:0];
						if (!dev_valid(sampled)) begin
							res.tx_byte      = BAD_SELECT_CODE;
							res.select_error = 1'b1;
						end else if (item.rx_byte[READ_FLAG_BIT]) begin
							mreq.re       = 1'b1;
							mreq.rd_dev   = sampled;
							mreq.rd_addr  = item.rx_byte[6:0];
							res.use_rdata = 1'b1;
						end
					end else if (!dev_valid(dev_q)) begin
						res.tx_byte      = BAD_SELECT_CODE;
						res.select_error = 1'b1;
					end else if (read_mode_q) begin
						// pre-increment, then read
						ptr_d         = ptr_inc;
						mreq.re       = 1'b1;
						mreq.rd_dev   = dev_q;
						mreq.rd_addr  = ptr_inc;
						res.use_rdata = 1'b1;
					end else begin
						mreq.we      = is_writable(dev_q, ptr_q);
						mreq.wr_dev  = dev_q;
						mreq.wr_addr = ptr_q;
						mreq.wr_data = item.rx_byte;
						ptr_d        = ptr_inc;
					end
				end
			end
			default: begin
				in_trans_d = in_trans_q;
			end
		endcase
		// drop the bank read and write unless the item advances this cycle
		if (!fire) begin
			mreq.we = 1'b0;
			mreq.re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q       <= DEV_NO_SEL;
			in_trans_q  <= 1'b0;
			await_cmd_q <= 1'b1;
			ptr_q       <= 7'd0;
			read_mode_q <= 1'b0;
		end else if (fire) begin
			dev_q       <= dev_d;
			in_trans_q  <= in_trans_d;
			await_cmd_q <= await_cmd_d;
			ptr_q       <= ptr_d;
			read_mode_q <= read_mode_d;
		end
	end

endmodule

### src/mdspi_chk.sv
// ---------------------------------------------------------------------------
// mdspi_chk
// Port-level checks for the multi-device SPI slave, bound to the top level.
// ---------------------------------------------------------------------------
module mdspi_chk
	import mdspi_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a select error always answers the bad-select code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.select_error |-> out_data.tx_byte == BAD_SELECT_CODE)
		else $error("select error without bad-select code");

	// a fresh result comes from an accepted item, by way of item_s1 and the output stage
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted item");

	// an accepted item passes item_s1 and reaches the output unless the output stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("accepted item did not reach the output");

endmodule

bind multi_device_spi_register_slave mdspi_chk u_chk (.*);
